FILE: sv/ctd_pkg.sv
// Shared types and constants for the chunked transfer decoder.
`timescale 1ns / 1ps

package ctd_pkg;

    localparam int LEN_BITS = 32;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        ERR_LEN_CHAR   = 3'd0,
        ERR_EXT_CHAR   = 3'd1,
        ERR_LEN_NO_LF  = 3'd2,
        ERR_DATA_NO_CR = 3'd3,
        ERR_DATA_NO_LF = 3'd4,
        ERR_OVERFLOW   = 3'd5,
        ERR_TRUNCATED  = 3'd6
    } t_err_code;

    typedef struct packed {
        logic      consumed;
        logic      body_valid;
        logic [7:0] body_byte;
        logic      body_finished;
        logic      error_valid;
        t_err_code error_code;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    // ASCII hex digit decode
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: sv/chunked_transfer_decoder_core.sv
// Chunked transfer decoder: byte-at-a-time parser of an HTTP chunked body.
//
// Input channel (i_valid / o_ready) carries one transfer per byte event:
// i_action = 0 for a data byte on i_data_byte, 1 for the end-of-stream
// finish event. Output channel (o_valid / i_ready) returns exactly one
// result per input transfer: consumed flag, decoded payload byte, body
// finished, and error report.
// Two register stages: the input register holds the accepted transfer, the
// parse state and result are updated from it into the output register.
// o_valid rises once the output register is loaded from the input register;
// throughput is one transfer per cycle while the receiver does not stall,
// limited only by the single parse-state update.
// When the receiver stalls, the output register holds its result and the
// input register can still take one more transfer; o_ready then drops
// until the output is taken.
// Reset (i_rst_n low, synchronous) empties both stages and returns the
// parser to the chunk length phase with a zero length. After an error or
// the end of the trailer the parser stays stopped until reset.
`timescale 1ns / 1ps

module chunked_transfer_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_consumed,
    output logic       o_body_valid,
    output logic [7:0] o_body_byte,
    output logic       o_body_finished,
    output logic       o_error_valid,
    output logic [2:0] o_error_code
);

    typedef enum logic [7:0] {
        PH_LEN     = 8'b0000_0001,
        PH_EXT     = 8'b0000_0010,
        PH_LEN_LF  = 8'b0000_0100,
        PH_DATA    = 8'b0000_1000,
        PH_DATA_CR = 8'b0001_0000,
        PH_DATA_LF = 8'b0010_0000,
        PH_TRAILER = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    logic                          r_in_valid;
    logic                          r_action;
    logic [7:0]                    r_byte;
    logic                          r_out_valid;
    ctd_pkg::t_result              r_out;
    t_phase                        r_phase;
    logic [ctd_pkg::LEN_BITS-1:0]  r_len;
    logic                          r_tr_started;
    logic                          r_tr_cr;

    t_phase                        n_phase;
    logic [ctd_pkg::LEN_BITS-1:0]  n_len;
    logic                          n_tr_started;
    logic                          n_tr_cr;
    ctd_pkg::t_result              n_out;

    logic                          advance;
    ctd_pkg::t_hex                 hex;
    logic [ctd_pkg::LEN_BITS-1:0]  len_dec;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign hex     = ctd_pkg::hex_decode(r_byte);
    assign len_dec = r_len - ctd_pkg::LEN_BITS'(1);

    always_comb begin
        n_phase      = r_phase;
        n_len        = r_len;
        n_tr_started = r_tr_started;
        n_tr_cr      = r_tr_cr;
        n_out        = '0;
        n_out.error_code = ctd_pkg::ERR_LEN_CHAR;
        if (r_action) begin
            if (r_phase != PH_DONE) begin
                n_out.error_valid = 1'b1;
                n_out.error_code  = ctd_pkg::ERR_TRUNCATED;
                n_phase           = PH_DONE;
            end
        end else if (r_phase != PH_DONE) begin
            n_out.consumed = 1'b1;
            case (r_phase)
                PH_LEN: begin
                    if (hex.ok) begin
                        if (r_len[ctd_pkg::LEN_BITS-1 -: 4] != 4'd0) begin
                            n_out.error_valid = 1'b1;
                            n_out.error_code  = ctd_pkg::ERR_OVERFLOW;
                        end else begin
                            n_len = {r_len[ctd_pkg::LEN_BITS-5:0], hex.value};
                        end
                    end else if (r_byte == ctd_pkg::CH_CR) begin
                        n_phase = PH_LEN_LF;
                    end else if (r_byte == ctd_pkg::CH_SEMI) begin
                        n_phase = PH_EXT;
                    end else begin
                        n_out.error_valid = 1'b1;
                        n_out.error_code  = ctd_pkg::ERR_LEN_CHAR;
                    end
                end
                PH_EXT: begin
                    if (r_byte == ctd_pkg::CH_CR) begin
                        n_phase = PH_LEN_LF;
                    end else if (r_byte < ctd_pkg::CH_SPACE || r_byte[7]) begin
                        n_out.error_valid = 1'b1;
                        n_out.error_code  = ctd_pkg::ERR_EXT_CHAR;
                    end
                end
                PH_LEN_LF: begin
                    if (r_byte == ctd_pkg::CH_LF) begin
                        if (r_len == '0) begin
                            n_phase      = PH_TRAILER;
                            n_tr_started = 1'b0;
                            n_tr_cr      = 1'b0;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_out.error_valid = 1'b1;
                        n_out.error_code  = ctd_pkg::ERR_LEN_NO_LF;
                    end
                end
                PH_DATA: begin
                    n_out.body_valid = 1'b1;
                    n_out.body_byte  = r_byte;
                    n_len            = len_dec;
                    if (len_dec == '0) begin
                        n_phase = PH_DATA_CR;
                    end
                end
                PH_DATA_CR: begin
                    if (r_byte == ctd_pkg::CH_CR) begin
                        n_phase = PH_DATA_LF;
                    end else begin
                        n_out.error_valid = 1'b1;
                        n_out.error_code  = ctd_pkg::ERR_DATA_NO_CR;
                    end
                end
                PH_DATA_LF: begin
                    if (r_byte == ctd_pkg::CH_LF) begin
                        n_phase = PH_LEN;
                        n_len   = '0;
                    end else begin
                        n_out.error_valid = 1'b1;
                        n_out.error_code  = ctd_pkg::ERR_DATA_NO_LF;
                    end
                end
                PH_TRAILER: begin
                    if (r_byte == ctd_pkg::CH_LF && r_tr_cr) begin
                        // CR LF on an empty line ends the body
                        if (!r_tr_started) begin
                            n_out.body_finished = 1'b1;
                            n_phase             = PH_DONE;
                        end
                        n_tr_started = 1'b0;
                        n_tr_cr      = 1'b0;
                    end else if (r_byte == ctd_pkg::CH_CR) begin
                        if (r_tr_cr) begin
                            n_tr_started = 1'b1;
                        end
                        n_tr_cr = 1'b1;
                    end else begin
                        n_tr_started = 1'b1;
                        n_tr_cr      = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (n_out.error_valid) begin
                n_out.consumed = 1'b0;
                n_phase        = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= PH_LEN;
            r_len        <= '0;
            r_tr_started <= 1'b0;
            r_tr_cr      <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_phase      <= n_phase;
                r_len        <= n_len;
                r_tr_started <= n_tr_started;
                r_tr_cr      <= n_tr_cr;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_action <= i_action;
            r_byte   <= i_data_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_consumed      = r_out.consumed;
    assign o_body_valid    = r_out.body_valid;
    assign o_body_byte     = r_out.body_byte;
    assign o_body_finished = r_out.body_finished;
    assign o_error_valid   = r_out.error_valid;
    assign o_error_code    = r_out.error_code;

    // data phase is only ever entered or held with bytes still owed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_len != '0))
        else $error("data phase with zero length left");

    // a reported error or finished body leaves the parser stopped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.error_valid || r_out.body_finished)) |-> (r_phase == PH_DONE))
        else $error("parser not stopped after error or finish");

    // an error byte is never reported as consumed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_valid) |-> !r_out.consumed)
        else $error("error byte marked consumed");

    // payload bytes only come from consumed data transfers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.body_valid) |-> (r_out.consumed && !r_out.error_valid))
        else $error("payload byte without consume");

    // once stopped, the parser never resumes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_phase) == PH_DONE && $past(i_rst_n)) |-> (r_phase == PH_DONE))
        else $error("parser left stopped state");

endmodule

FILE: test/chunked_transfer_decoder_core_tb.sv
// Self-checking testbench for the chunked transfer decoder core.
`timescale 1ns / 1ps

module chunked_transfer_decoder_core_tb;

    localparam logic ACT_BYTE       = 1'b0;
    localparam logic ACT_FINISH     = 1'b1;
    localparam int   RANDOM_ITEMS   = 1880;
    localparam int   WATCHDOG_LIMIT = 1000;
    localparam int   TAIL_CYCLES    = 8;

    typedef enum logic [2:0] {
        S_LEN, S_EXT, S_LEN_LF, S_DATA, S_DATA_CR, S_DATA_LF, S_TRAILER, S_STOPPED
    } t_parse;

    typedef enum int {
        END_TRAILER, END_EMPTY_LINE, END_LEN_CHAR, END_EXT_CHAR, END_LEN_NO_LF,
        END_DATA_NO_CR, END_DATA_NO_LF, END_OVERFLOW, END_TRUNCATED
    } t_ending;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_action    = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_consumed;
    logic       o_body_valid;
    logic [7:0] o_body_byte;
    logic       o_body_finished;
    logic       o_error_valid;
    logic [2:0] o_error_code;

    // parser model state
    t_parse                       parse_ph    = S_LEN;
    logic [ctd_pkg::LEN_BITS-1:0] chunk_left  = '0;
    bit                           trl_started = 1'b0;
    bit                           trl_cr      = 1'b0;

    ctd_pkg::t_result decoded_q[$];
    int               mismatch_count = 0;
    int               sent_items     = 0;
    int               rx_hold        = 0;
    int               idle_cycles    = 0;
    bit               quiet_mode     = 1'b0;

    chunked_transfer_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_consumed     (o_consumed),
        .o_body_valid   (o_body_valid),
        .o_body_byte    (o_body_byte),
        .o_body_finished(o_body_finished),
        .o_error_valid  (o_error_valid),
        .o_error_code   (o_error_code)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        return 5'b0;
    endfunction

    // letters come out in either case
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic int draw_wait();
        return quiet_mode ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic ctd_pkg::t_result decode_byte(input logic act, input logic [7:0] c);
        ctd_pkg::t_result r;
        logic [4:0]       hx;
        r = '0;
        if (act == ACT_FINISH) begin
            if (parse_ph != S_STOPPED) begin
                r.error_valid = 1'b1;
                r.error_code  = ctd_pkg::ERR_TRUNCATED;
                parse_ph      = S_STOPPED;
            end
        end else if (parse_ph != S_STOPPED) begin
            r.consumed = 1'b1;
            case (parse_ph)
                S_LEN: begin
                    hx = hex_digit(c);
                    if (hx[4]) begin
                        if (chunk_left[ctd_pkg::LEN_BITS-1 -: 4] != 4'd0) begin
                            r.error_valid = 1'b1;
                            r.error_code  = ctd_pkg::ERR_OVERFLOW;
                        end else begin
                            chunk_left = {chunk_left[ctd_pkg::LEN_BITS-5:0], hx[3:0]};
                        end
                    end else if (c == ctd_pkg::CH_CR) begin
                        parse_ph = S_LEN_LF;
                    end else if (c == ctd_pkg::CH_SEMI) begin
                        parse_ph = S_EXT;
                    end else begin
                        r.error_valid = 1'b1;
                        r.error_code  = ctd_pkg::ERR_LEN_CHAR;
                    end
                end
                S_EXT: begin
                    if (c == ctd_pkg::CH_CR) begin
                        parse_ph = S_LEN_LF;
                    end else if (c < ctd_pkg::CH_SPACE || c >= 8'h80) begin
                        r.error_valid = 1'b1;
                        r.error_code  = ctd_pkg::ERR_EXT_CHAR;
                    end
                end
                S_LEN_LF: begin
                    if (c != ctd_pkg::CH_LF) begin
                        r.error_valid = 1'b1;
                        r.error_code  = ctd_pkg::ERR_LEN_NO_LF;
                    end else if (chunk_left == '0) begin
                        parse_ph    = S_TRAILER;
                        trl_started = 1'b0;
                        trl_cr      = 1'b0;
                    end else begin
                        parse_ph = S_DATA;
                    end
                end
                S_DATA: begin
                    r.body_valid = 1'b1;
                    r.body_byte  = c;
                    chunk_left   = chunk_left - ctd_pkg::LEN_BITS'(1);
                    if (chunk_left == '0) parse_ph = S_DATA_CR;
                end
                S_DATA_CR: begin
                    if (c == ctd_pkg::CH_CR) begin
                        parse_ph = S_DATA_LF;
                    end else begin
                        r.error_valid = 1'b1;
                        r.error_code  = ctd_pkg::ERR_DATA_NO_CR;
                    end
                end
                S_DATA_LF: begin
                    if (c == ctd_pkg::CH_LF) begin
                        parse_ph   = S_LEN;
                        chunk_left = '0;
                    end else begin
                        r.error_valid = 1'b1;
                        r.error_code  = ctd_pkg::ERR_DATA_NO_LF;
                    end
                end
                S_TRAILER: begin
                    // line content is not checked; only CR LF on an empty line matters
                    if (c == ctd_pkg::CH_LF && trl_cr) begin
                        if (!trl_started) begin
                            r.body_finished = 1'b1;
                            parse_ph        = S_STOPPED;
                        end
                        trl_started = 1'b0;
                        trl_cr      = 1'b0;
                    end else if (c == ctd_pkg::CH_CR) begin
                        if (trl_cr) trl_started = 1'b1;
                        trl_cr = 1'b1;
                    end else begin
                        trl_started = 1'b1;
                        trl_cr      = 1'b0;
                    end
                end
                default: ;
            endcase
            if (r.error_valid) begin
                r.consumed = 1'b0;
                parse_ph   = S_STOPPED;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input logic act, input logic [7:0] c);
        int gap;
        gap = draw_wait();
        decoded_q.push_back(decode_byte(act, c));
        sent_items++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_data_byte <= c;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_q.size() != 0);
    endtask

    // one chunk; a zero length enters the trailer
    task automatic send_chunk(input int unsigned len, input bit empty_line);
        int ndig;
        ndig = 1;
        while (ndig < 8 && (len >> (4 * ndig)) != 0) ndig++;
        if (!(len == 0 && empty_line)) begin
            repeat ($urandom_range(0, 2)) send_item(ACT_BYTE, 8'h30);
            for (int i = ndig - 1; i >= 0; i--) begin
                send_item(ACT_BYTE, hex_char(4'(len >> (4 * i))));
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item(ACT_BYTE, ctd_pkg::CH_SEMI);
            repeat ($urandom_range(0, 5)) send_item(ACT_BYTE, 8'($urandom_range(32, 127)));
        end
        send_item(ACT_BYTE, ctd_pkg::CH_CR);
        send_item(ACT_BYTE, ctd_pkg::CH_LF);
        if (len != 0) begin
            repeat (len) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            send_item(ACT_BYTE, ctd_pkg::CH_CR);
            send_item(ACT_BYTE, ctd_pkg::CH_LF);
        end
    endtask

    task automatic test_directed();
        logic [7:0] seq [22];
        // extension bytes at the accepted extremes (20h, 7Fh), then an 8-digit length with leading zeros
        seq = '{8'h31, ctd_pkg::CH_SEMI, ctd_pkg::CH_SPACE, 8'h7F, ctd_pkg::CH_CR,
                ctd_pkg::CH_LF, 8'h00, ctd_pkg::CH_CR, ctd_pkg::CH_LF,
                8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h31,
                ctd_pkg::CH_CR, ctd_pkg::CH_LF, 8'hFF, ctd_pkg::CH_CR, ctd_pkg::CH_LF};
        foreach (seq[k]) send_item(ACT_BYTE, seq[k]);
    endtask

    task automatic test_random_chunks();
        int first;
        int len;
        first = sent_items;
        while (sent_items - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) quiet_mode = ~quiet_mode;
            if ($urandom_range(0, 24) == 0) pause_until_drained();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200)
                                              : $urandom_range(1, 16);
            send_chunk(len, 1'b0);
        end
        quiet_mode = 1'b0;
    endtask

    // the block stops for good, so one way of ending is picked per run
    task automatic test_termination();
        t_ending    ending;
        logic [7:0] b;
        logic [4:0] hx;
        int         n;
        int         trl_len;
        ending = t_ending'($urandom_range(0, 8));
        $display("body ends with %s", ending.name());
        case (ending)
            END_TRAILER, END_EMPTY_LINE: begin
                send_chunk(0, ending == END_EMPTY_LINE);
                trl_len = $urandom_range(0, 40);
                n = 0;
                while (parse_ph != S_STOPPED) begin
                    if (n < trl_len) begin
                        case ($urandom_range(0, 3))
                            0: b = ctd_pkg::CH_CR;
                            1: b = ctd_pkg::CH_LF;
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                    end else begin
                        // CR LF pairs close any open line, then end the body
                        b = ((n - trl_len) % 2 == 0) ? ctd_pkg::CH_CR : ctd_pkg::CH_LF;
                    end
                    send_item(ACT_BYTE, b);
                    n++;
                end
            end
            END_LEN_CHAR: begin
                repeat ($urandom_range(0, 3)) begin
                    send_item(ACT_BYTE, hex_char(4'($urandom_range(0, 15))));
                end
                do begin
                    b  = 8'($urandom_range(0, 255));
                    hx = hex_digit(b);
                end while (hx[4] || b == ctd_pkg::CH_CR || b == ctd_pkg::CH_SEMI);
                send_item(ACT_BYTE, b);
            end
            END_EXT_CHAR: begin
                send_item(ACT_BYTE, hex_char(4'($urandom_range(0, 15))));
                send_item(ACT_BYTE, ctd_pkg::CH_SEMI);
                repeat ($urandom_range(0, 3)) send_item(ACT_BYTE, 8'($urandom_range(32, 127)));
                do b = 8'($urandom_range(0, 255));
                while (!((b < ctd_pkg::CH_SPACE && b != ctd_pkg::CH_CR) || b >= 8'h80));
                send_item(ACT_BYTE, b);
            end
            END_LEN_NO_LF: begin
                send_item(ACT_BYTE, hex_char(4'($urandom_range(0, 15))));
                send_item(ACT_BYTE, ctd_pkg::CH_CR);
                do b = 8'($urandom_range(0, 255)); while (b == ctd_pkg::CH_LF);
                send_item(ACT_BYTE, b);
            end
            END_DATA_NO_CR, END_DATA_NO_LF: begin
                n = $urandom_range(1, 15);
                send_item(ACT_BYTE, hex_char(4'(n)));
                send_item(ACT_BYTE, ctd_pkg::CH_CR);
                send_item(ACT_BYTE, ctd_pkg::CH_LF);
                repeat (n) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
                if (ending == END_DATA_NO_LF) send_item(ACT_BYTE, ctd_pkg::CH_CR);
                do b = 8'($urandom_range(0, 255));
                while (b == ((ending == END_DATA_NO_LF) ? ctd_pkg::CH_LF : ctd_pkg::CH_CR));
                send_item(ACT_BYTE, b);
            end
            END_OVERFLOW: begin
                // nonzero lead digit: the ninth digit no longer fits
                send_item(ACT_BYTE, hex_char(4'($urandom_range(1, 15))));
                repeat (8) send_item(ACT_BYTE, hex_char(4'($urandom_range(0, 15))));
            end
            END_TRUNCATED: begin
                n = $urandom_range(1, 15);
                send_item(ACT_BYTE, hex_char(4'(n)));
                send_item(ACT_BYTE, ctd_pkg::CH_CR);
                send_item(ACT_BYTE, ctd_pkg::CH_LF);
                repeat ($urandom_range(0, n - 1)) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
                send_item(ACT_FINISH, 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endtask

    // once stopped, bytes are refused and a finish event does nothing
    task automatic test_stopped();
        send_item(ACT_FINISH, 8'($urandom_range(0, 255)));
        repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // result side: random stall after every transfer
    always @(posedge i_clk) begin : result_ready
        int w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold <= 0;
        end else if (o_valid && i_ready) begin
            w = draw_wait();
            rx_hold <= w;
            i_ready <= (w == 0);
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= (rx_hold == 1);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        ctd_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("transfer with nothing pending", 1, 0);
            end else begin
                want = decoded_q.pop_front();
                if (o_consumed !== want.consumed)
                    report_mismatch("consumed", int'(o_consumed), int'(want.consumed));
                if (o_body_valid !== want.body_valid)
                    report_mismatch("body_valid", int'(o_body_valid), int'(want.body_valid));
                if (o_body_byte !== want.body_byte)
                    report_mismatch("body_byte", int'(o_body_byte), int'(want.body_byte));
                if (o_body_finished !== want.body_finished)
                    report_mismatch("body_finished", int'(o_body_finished),
                                    int'(want.body_finished));
                if (o_error_valid !== want.error_valid)
                    report_mismatch("error_valid", int'(o_error_valid), int'(want.error_valid));
                if (o_error_code !== want.error_code)
                    report_mismatch("error_code", int'(o_error_code), int'(want.error_code));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        pause_until_drained();
        test_random_chunks();
        test_termination();
        test_stopped();
        i_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
